// ===== src/pca_pkg.sv =====
// Shared types and constants of the pileup coverage accumulator.
package pca_pkg;

  localparam int TID_W  = 16;
  localparam int POS_W  = 31;
  localparam int QUAL_W = 8;
  localparam int DEP_W  = 48;
  localparam int QS_W   = 56;
  localparam int BIN_W  = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [POS_W-1:0] MAX31 = '1;
  localparam logic [DEP_W-1:0] MAX48 = '1;
  localparam logic [QS_W-1:0]  MAX56 = '1;

  localparam logic [BIN_W-1:0] BIN_COUNT_RST = 6'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd5;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  // One classified input beat as it sits in the queue.
  typedef struct packed {
    logic              flush;
    logic [TID_W-1:0]  tid;
    logic [POS_W-1:0]  tlen;
    logic [POS_W-1:0]  pos;
    logic              keep;
    logic              hasq;
    logic [QUAL_W-1:0] qual;
    logic              lastpos;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [TID_W-1:0]  target;
    logic [POS_W-1:0]  span_begin;
    logic [POS_W-1:0]  span_end;
    logic [POS_W-1:0]  covered;
    logic [DEP_W-1:0]  depth;
    logic [QS_W-1:0]   qsum;
    logic [BIN_W-1:0]  bin_index;
    logic [POS_W-1:0]  bin_value;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [POS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/pca_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
module pca_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [15:0]           target_id,
  input  logic [30:0]           target_length,
  input  logic [30:0]           position,
  input  logic                  is_deletion,
  input  logic                  is_ref_skip,
  input  logic                  has_quality,
  input  logic [7:0]            base_qual,
  input  logic                  last_at_position,
  input  logic [7:0]            min_base_qual,
  output logic                  q_valid,
  output pca_pkg::item_t        q_item,
  input  logic                  q_pop
);
  import pca_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.flush   = action;
    cls.tid     = target_id;
    cls.tlen    = target_length;
    cls.pos     = position;
    cls.keep    = !is_deletion && !is_ref_skip && !(has_quality && base_qual < min_base_qual);
    cls.hasq    = has_quality;
    cls.qual    = base_qual;
    cls.lastpos = last_at_position;
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== src/pca_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module pca_div (
  input  logic                clk,
  input  logic                rst,
  input  pca_pkg::div_req_t   req,
  output pca_pkg::div_rsp_t   rsp
);
  import pca_pkg::*;

  logic [POS_W-1:0] rem;
  logic [POS_W-1:0] quo;
  logic [POS_W-1:0] dvs;
  logic [4:0]       cnt;
  logic             run;
  logic [POS_W:0]   shifted;
  logic [POS_W+1:0] trial;

  assign shifted = {rem, quo[POS_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  assign rsp.busy     = run;
  assign rsp.done     = run && (cnt == 5'd0);
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (run && cnt != 5'd0) begin
      if (trial[POS_W+1]) begin
        rem <= shifted[POS_W-1:0];
        quo <= {quo[POS_W-2:0], 1'b0};
      end else begin
        rem <= trial[POS_W-1:0];
        quo <= {quo[POS_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= 5'd0;
    end else if (req.start) begin
      run <= 1'b1;
      cnt <= 5'(POS_W);
    end else if (run) begin
      if (cnt == 5'd0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 5'd1;
      end
    end
  end

endmodule

// ===== src/pca_back.sv =====
// Back end: accumulates per-target coverage, keeps the bin store and emits results.
module pca_back #(
  parameter int MAX_BINS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pca_pkg::item_t      q_item,
  output logic                q_pop,
  input  logic                region_enable,
  input  logic [30:0]         region_begin,
  input  logic [30:0]         region_end,
  input  logic                hist_enable,
  input  logic [5:0]          bin_count,
  output pca_pkg::div_req_t   div_req,
  input  pca_pkg::div_rsp_t   div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output pca_pkg::res_t       out_res
);
  import pca_pkg::*;

  localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [BIN_W-1:0] MAXB = BIN_W'(MAX_BINS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TDIV  = 7'b0000010,
    ST_ENTRY = 7'b0000100,
    ST_BDIV  = 7'b0001000,
    ST_BRD   = 7'b0010000,
    ST_ESUM  = 7'b0100000,
    ST_EBIN  = 7'b1000000
  } state_t;

  state_t            state;
  logic              tv;
  logic [TID_W-1:0]  active_target;
  logic [POS_W-1:0]  span_limit;
  logic [POS_W-1:0]  bw;
  logic [BIN_W-1:0]  biu;
  logic [POS_W-1:0]  cov;
  logic [DEP_W-1:0]  dep;
  logic [QS_W-1:0]   qs;
  logic              pk;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     bidx;
  logic [POS_W-1:0]  mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld;
  logic [POS_W-1:0]  rdata;
  logic              rvld;

  logic [POS_W-1:0]  beg;
  logic [POS_W-1:0]  lim_new;
  logic [POS_W-1:0]  len;
  logic [BIN_W-1:0]  cap;
  logic [BIN_W-1:0]  nb_new;
  logic              in_span;
  logic              keep_in;
  logic              kept_now;
  logic [QS_W:0]     qsum;
  logic [BIN_W-1:0]  nb_emit;
  logic              slot_free;
  logic              out_load;
  logic              last_bin;
  logic              new_tgt;
  logic [POS_W-1:0]  cur_bin;
  logic [POS_W-1:0]  inc_bin;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic              clr_acc;
  logic              bin_go;

  always_comb begin
    beg       = region_enable ? region_begin : '0;
    lim_new   = region_enable ? region_end : q_item.tlen;
    len       = (lim_new > beg) ? lim_new - beg : '0;
    cap       = (bin_count < MAXB) ? bin_count : MAXB;
    nb_new    = (len < POS_W'(cap)) ? len[BIN_W-1:0] : cap;
    in_span   = (q_item.pos >= beg) && (q_item.pos < span_limit);
    keep_in   = in_span && q_item.keep;
    kept_now  = pk || keep_in;
    qsum      = {1'b0, qs} + (QS_W+1)'(q_item.qual);
    nb_emit   = hist_enable ? biu : '0;
    slot_free = !out_valid || out_ready;
    out_load  = slot_free && ((state == ST_ESUM) || (state == ST_EBIN));
    last_bin  = (BIN_W'(idx) + BIN_W'(1)) == nb_emit;
    new_tgt   = !tv || (q_item.tid != active_target);
    cur_bin   = rvld ? rdata : '0;
    inc_bin   = (cur_bin == MAX31) ? cur_bin : cur_bin + POS_W'(1);
    bin_go    = q_item.lastpos && kept_now && hist_enable && in_span && (bw != '0);
  end

  // Handshake toward the queue, divider requests and memory port control.
  always_comb begin
    q_pop   = 1'b0;
    div_req = '0;
    rd_addr = '0;
    mem_we  = 1'b0;
    clr_acc = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.flush && !tv) begin
            q_pop = 1'b1;
          end else if (!q_item.flush && !tv && nb_new != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = len;
            div_req.divisor  = POS_W'(nb_new);
          end
        end
      end
      ST_TDIV: ;
      ST_ENTRY: begin
        if (bin_go) begin
          div_req.start    = 1'b1;
          div_req.dividend = q_item.pos - beg;
          div_req.divisor  = bw;
        end else begin
          q_pop = 1'b1;
        end
      end
      ST_BDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < POS_W'(biu)) begin
            rd_addr = div_rsp.quotient[IW-1:0];
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      ST_BRD: begin
        q_pop  = 1'b1;
        mem_we = 1'b1;
      end
      ST_ESUM: begin
        if (slot_free && nb_emit == '0) begin
          clr_acc = 1'b1;
          q_pop   = q_item.flush;
        end
      end
      ST_EBIN: begin
        rd_addr = idx;
        if (slot_free) begin
          if (last_bin) begin
            clr_acc = 1'b1;
            q_pop   = q_item.flush;
          end else begin
            rd_addr = idx + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bidx] <= inc_bin;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tv            <= 1'b0;
      active_target <= '0;
      span_limit    <= '0;
      bw            <= '0;
      biu           <= '0;
      cov           <= '0;
      dep           <= '0;
      qs            <= '0;
      pk            <= 1'b0;
      vld           <= '0;
      rvld          <= 1'b0;
      out_valid     <= 1'b0;
      idx           <= '0;
      bidx          <= '0;
    end else begin
      rvld <= vld[rd_addr];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clr_acc) begin
        cov   <= '0;
        dep   <= '0;
        qs    <= '0;
        pk    <= 1'b0;
        vld   <= '0;
        tv    <= 1'b0;
        state <= ST_IDLE;
      end else if (mem_we) begin
        vld[bidx] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.flush) begin
              if (tv) begin
                state <= ST_ESUM;
              end
            end else if (tv && new_tgt) begin
              state <= ST_ESUM;
            end else if (!tv) begin
              active_target <= q_item.tid;
              tv            <= 1'b1;
              span_limit    <= lim_new;
              biu           <= nb_new;
              if (nb_new == '0) begin
                bw    <= '0;
                state <= ST_ENTRY;
              end else begin
                state <= ST_TDIV;
              end
            end else begin
              state <= ST_ENTRY;
            end
          end
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            bw    <= div_rsp.quotient;
            state <= ST_ENTRY;
          end
        end
        ST_ENTRY: begin
          if (keep_in) begin
            if (dep != MAX48) begin
              dep <= dep + DEP_W'(1);
            end
            if (q_item.hasq) begin
              qs <= qsum[QS_W] ? MAX56 : qsum[QS_W-1:0];
            end
          end
          if (q_item.lastpos) begin
            pk <= 1'b0;
            if (kept_now && cov != MAX31) begin
              cov <= cov + POS_W'(1);
            end
          end else begin
            pk <= kept_now;
          end
          state <= bin_go ? ST_BDIV : ST_IDLE;
        end
        ST_BDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient < POS_W'(biu)) begin
              bidx  <= div_rsp.quotient[IW-1:0];
              state <= ST_BRD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_BRD: begin
          state <= ST_IDLE;
        end
        ST_ESUM: begin
          if (slot_free) begin
            out_res.kind       <= KIND_SUMMARY;
            out_res.target     <= active_target;
            out_res.span_begin <= beg;
            out_res.span_end   <= span_limit;
            out_res.covered    <= cov;
            out_res.depth      <= dep;
            out_res.qsum       <= qs;
            out_res.bin_index  <= '0;
            out_res.bin_value  <= '0;
            out_res.last       <= (nb_emit == '0);
            if (nb_emit != '0) begin
              idx   <= '0;
              state <= ST_EBIN;
            end
          end
        end
        ST_EBIN: begin
          if (slot_free) begin
            out_res.kind       <= KIND_BIN;
            out_res.target     <= active_target;
            out_res.span_begin <= beg;
            out_res.span_end   <= span_limit;
            out_res.covered    <= '0;
            out_res.depth      <= '0;
            out_res.qsum       <= '0;
            out_res.bin_index  <= BIN_W'(idx);
            out_res.bin_value  <= cur_bin;
            out_res.last       <= last_bin;
            if (!last_bin) begin
              idx <= idx + IW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Loading a summary into a free output slot raises out_valid.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ESUM && slot_free) |=> out_valid)
    else $error("summary beat not presented after load");

  // The divider is never restarted while it still works on an earlier request.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // The queue is only popped when it holds a beat.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // After a target is closed by a flush or a target change, the bin store reads as all zero.
  a_clear_bins: assert property (@(posedge clk) disable iff (rst)
    clr_acc |=> (vld == '0) && !tv)
    else $error("bin store not cleared after flush");

endmodule

// ===== src/pileup_coverage_accumulator.sv =====
// Top level of the pileup coverage accumulator: configuration registers and block wiring.
// An ordinary entry passes through ST_IDLE and ST_ENTRY in the back end, which pops its queue beat.
// Closing an in-span covered position, histogram on, bw != 0, adds a serial divide (ST_BDIV) and a
// read-modify-write of the bin store (ST_BRD); a target start adds the bin-width divide (ST_TDIV).
// A flush or target change emits one beat per cycle while out_ready is high, 1 + bins beats.
// Synchronous active-high reset clears control, accumulators and bin valid bits.
module pileup_coverage_accumulator #(
  parameter int MAX_BINS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] target_id,
  input  logic [30:0] target_length,
  input  logic [30:0] position,
  input  logic        is_deletion,
  input  logic        is_ref_skip,
  input  logic        has_quality,
  input  logic [7:0]  base_qual,
  input  logic        last_at_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [15:0] out_target,
  output logic [30:0] span_begin,
  output logic [30:0] span_end,
  output logic [30:0] covered_bases,
  output logic [47:0] depth_sum,
  output logic [55:0] qual_sum,
  output logic [5:0]  bin_index,
  output logic [30:0] bin_value,
  output logic        last
);
  import pca_pkg::*;

  // Configuration registers. They are to be written only while the block is idle, so the back end
  // reads them live; the block itself does not enforce this.
  logic [7:0]  min_base_qual;
  logic        region_enable;
  logic [30:0] region_begin;
  logic [30:0] region_end;
  logic        hist_enable;
  logic [5:0]  bin_count;

  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_base_qual <= '0;
      region_enable <= 1'b0;
      region_begin  <= '0;
      region_end    <= '0;
      hist_enable   <= 1'b0;
      bin_count     <= BIN_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_QUAL:   min_base_qual <= cfg_data[7:0];
        CFG_REGION_EN:  region_enable <= cfg_data[0];
        CFG_REGION_BEG: region_begin  <= cfg_data;
        CFG_REGION_END: region_end    <= cfg_data;
        CFG_HIST_EN:    hist_enable   <= cfg_data[0];
        CFG_BIN_COUNT:  bin_count     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each beat (deletion, ref skip, quality limit) and queues it in two
  // slots, so input can run ahead of the back end until both slots are full.
  pca_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .target_id        (target_id),
    .target_length    (target_length),
    .position         (position),
    .is_deletion      (is_deletion),
    .is_ref_skip      (is_ref_skip),
    .has_quality      (has_quality),
    .base_qual        (base_qual),
    .last_at_position (last_at_position),
    .min_base_qual    (min_base_qual),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  // One shared divider serves both the bin width at target start and the bin
  // number of each covered position while the histogram is on.
  pca_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // The back end owns the accumulators, the bin store and the output register.
  pca_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .region_enable (region_enable),
    .region_begin  (region_begin),
    .region_end    (region_end),
    .hist_enable   (hist_enable),
    .bin_count     (bin_count),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res       (res)
  );

  assign kind          = res.kind;
  assign out_target    = res.target;
  assign span_begin    = res.span_begin;
  assign span_end      = res.span_end;
  assign covered_bases = res.covered;
  assign depth_sum     = res.depth;
  assign qual_sum      = res.qsum;
  assign bin_index     = res.bin_index;
  assign bin_value     = res.bin_value;
  assign last          = res.last;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the pileup coverage accumulator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pca_pkg::*;

  // Clock, reset and the block's ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [30:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = 1'b0;
  logic [15:0]       target_id = '0;
  logic [30:0]       target_length = '0;
  logic [30:0]       position = '0;
  logic              is_deletion = 1'b0;
  logic              is_ref_skip = 1'b0;
  logic              has_quality = 1'b0;
  logic [7:0]        base_qual = '0;
  logic              last_at_position = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [15:0]       out_target;
  logic [30:0]       span_begin;
  logic [30:0]       span_end;
  logic [30:0]       covered_bases;
  logic [47:0]       depth_sum;
  logic [55:0]       qual_sum;
  logic [5:0]        bin_index;
  logic [30:0]       bin_value;
  logic              last;

  pileup_coverage_accumulator i_dut (.*);

  // Shadow copy of the configuration registers.
  logic [7:0]        m_min_qual;
  logic              m_region_en;
  logic [30:0]       m_region_beg;
  logic [30:0]       m_region_end;
  logic              m_hist_en;
  logic [5:0]        m_bin_count;

  // Shadow copy of the per-target accumulators.
  logic [15:0]       m_target;
  logic              m_target_valid;
  logic [30:0]       m_span_limit;
  logic [30:0]       m_bin_width;
  logic [5:0]        m_bins_used;
  logic [30:0]       m_covered;
  logic [47:0]       m_depth;
  logic [55:0]       m_qsum;
  logic              m_pos_kept;
  logic [30:0]       m_bins [0:62];

  // Results waiting to be seen on the output.
  res_t              coverage_q[$];
  bit                failed = 1'b0;
  int unsigned       cycle_count = 0;
  int unsigned       long_hold = 0;
  bit                allow_idle = 1'b1;

  function automatic logic [30:0] span_start_now();
    return m_region_en ? m_region_beg : '0;
  endfunction

  function automatic void clear_coverage();
    m_covered = '0;
    m_depth = '0;
    m_qsum = '0;
    m_pos_kept = 1'b0;
    for (int i = 0; i < 63; i++) m_bins[i] = '0;
  endfunction

  function automatic void push_result(logic k, logic [30:0] cov, logic [47:0] dep,
                                      logic [55:0] qs, logic [5:0] bi, logic [30:0] bv,
                                      logic lst);
    res_t r;
    r.kind = k;
    r.target = m_target;
    r.span_begin = span_start_now();
    r.span_end = m_span_limit;
    r.covered = cov;
    r.depth = dep;
    r.qsum = qs;
    r.bin_index = bi;
    r.bin_value = bv;
    r.last = lst;
    coverage_q.push_back(r);
  endfunction

  // Emit the finished target's summary and its bins, then clear.
  function automatic void close_target();
    int nb;
    if (!m_target_valid) return;
    nb = m_hist_en ? int'(m_bins_used) : 0;
    push_result(KIND_SUMMARY, m_covered, m_depth, m_qsum, '0, '0, nb == 0);
    for (int i = 0; i < nb; i++)
      push_result(KIND_BIN, '0, '0, '0, 6'(i), m_bins[i], i + 1 == nb);
    clear_coverage();
    m_target_valid = 1'b0;
  endfunction

  function automatic void open_target(logic [15:0] tid, logic [30:0] tlen);
    logic [30:0] beg;
    logic [30:0] len;
    logic [30:0] nb;
    beg = span_start_now();
    m_target = tid;
    m_target_valid = 1'b1;
    m_span_limit = m_region_en ? m_region_end : tlen;
    len = (m_span_limit > beg) ? m_span_limit - beg : '0;
    nb = {25'd0, m_bin_count};
    if (nb > len) nb = len;
    m_bins_used = nb[5:0];
    m_bin_width = (nb != 0) ? len / nb : '0;
  endfunction

  // Predict the results caused by one accepted input beat.
  function automatic void predict_coverage(logic act, logic [15:0] tid, logic [30:0] tlen,
                                           logic [30:0] pos, logic del, logic skip,
                                           logic hasq, logic [7:0] q, logic lastpos);
    logic [30:0] beg;
    logic [30:0] b;
    logic        in_span;
    if (act) begin
      close_target();
      return;
    end
    if (!m_target_valid || tid != m_target) begin
      close_target();
      open_target(tid, tlen);
    end
    beg = span_start_now();
    in_span = (pos >= beg) && (pos < m_span_limit);
    if (in_span && !del && !skip && !(hasq && q < m_min_qual)) begin
      if (m_depth != MAX48) m_depth++;
      if (hasq) m_qsum = (MAX56 - m_qsum < q) ? MAX56 : m_qsum + q;
      m_pos_kept = 1'b1;
    end
    if (lastpos) begin
      if (m_pos_kept) begin
        if (m_covered != MAX31) m_covered++;
        if (m_hist_en && in_span && m_bin_width != 0) begin
          b = (pos - beg) / m_bin_width;
          if (b < m_bins_used && m_bins[b] != MAX31) m_bins[b]++;
        end
      end
      m_pos_kept = 1'b0;
    end
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!allow_idle || r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat; it is offered at a falling edge and held until accepted.
  // Valid stays high after acceptance so that beats can follow back to back;
  // a gap or drain() drops it.
  task automatic send_entry(logic act, logic [15:0] tid, logic [30:0] tlen,
                            logic [30:0] pos, logic del, logic skip, logic hasq,
                            logic [7:0] q, logic lastpos);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    action <= act;
    target_id <= tid;
    target_length <= tlen;
    position <= pos;
    is_deletion <= del;
    is_ref_skip <= skip;
    has_quality <= hasq;
    base_qual <= q;
    last_at_position <= lastpos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_coverage(act, tid, tlen, pos, del, skip, hasq, q, lastpos);
    @(negedge clk);
  endtask

  // Registers are only written while idle, with every result drained.
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_QUAL:   m_min_qual = val[7:0];
      CFG_REGION_EN:  m_region_en = val[0];
      CFG_REGION_BEG: m_region_beg = val;
      CFG_REGION_END: m_region_end = val;
      CFG_HIST_EN:    m_hist_en = val[0];
      CFG_BIN_COUNT:  m_bin_count = val[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop offering beats, wait for the queue to drain, then let a histogram divide finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (coverage_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] mq, logic ren, logic [30:0] rb, logic [30:0] re,
                            logic hen, logic [5:0] bc);
    drain();
    write_reg(CFG_MIN_QUAL, {23'd0, mq});
    write_reg(CFG_REGION_EN, {30'd0, ren});
    write_reg(CFG_REGION_BEG, rb);
    write_reg(CFG_REGION_END, re);
    write_reg(CFG_HIST_EN, {30'd0, hen});
    write_reg(CFG_BIN_COUNT, {25'd0, bc});
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (gap_len() == 0);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (coverage_q.size() == 0) begin
        $error("unexpected result beat: target %0d kind %0d", out_target, kind);
        failed = 1'b1;
      end else begin
        e = coverage_q.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind); failed = 1'b1;
        end
        if (out_target !== e.target) begin
          $error("out_target: expected %0d actual %0d", e.target, out_target);
          failed = 1'b1;
        end
        if (span_begin !== e.span_begin) begin
          $error("span_begin: expected %0d actual %0d", e.span_begin, span_begin);
          failed = 1'b1;
        end
        if (span_end !== e.span_end) begin
          $error("span_end: expected %0d actual %0d", e.span_end, span_end);
          failed = 1'b1;
        end
        if (covered_bases !== e.covered) begin
          $error("covered_bases: expected %0d actual %0d", e.covered, covered_bases);
          failed = 1'b1;
        end
        if (depth_sum !== e.depth) begin
          $error("depth_sum: expected %0d actual %0d", e.depth, depth_sum);
          failed = 1'b1;
        end
        if (qual_sum !== e.qsum) begin
          $error("qual_sum: expected %0d actual %0d", e.qsum, qual_sum);
          failed = 1'b1;
        end
        if (bin_index !== e.bin_index) begin
          $error("bin_index: expected %0d actual %0d", e.bin_index, bin_index);
          failed = 1'b1;
        end
        if (bin_value !== e.bin_value) begin
          $error("bin_value: expected %0d actual %0d", e.bin_value, bin_value);
          failed = 1'b1;
        end
        if (last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 8000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random entry on the current target, with an occasional noisy field.
  task automatic random_entry(logic [15:0] tid, logic [30:0] tlen, logic [30:0] pos,
                              logic lastpos);
    logic del;
    logic skip;
    del = ($urandom_range(0, 9) == 0);
    skip = ($urandom_range(0, 14) == 0);
    send_entry(1'b0, tid, tlen, pos, del, skip, $urandom_range(0, 5) != 0,
               8'($urandom), lastpos);
  endtask

  // Corner cases: field extremes, flush without target, masking, empty span.
  task automatic test_directed();
    set_config(8'd20, 1'b0, '0, '0, 1'b1, 6'd4);
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);              // flush with no target
    send_entry(1'b0, 16'd7, 31'd8, 31'd0, 0, 0, 1, 8'd255, 0);
    send_entry(1'b0, 16'd7, 31'd8, 31'd0, 1, 0, 1, 8'd30, 0);  // deletion
    send_entry(1'b0, 16'd7, 31'd8, 31'd0, 0, 1, 1, 8'd30, 1);  // ref skip
    send_entry(1'b0, 16'd7, 31'd8, 31'd3, 0, 0, 1, 8'd19, 1);  // below quality limit
    send_entry(1'b0, 16'd7, 31'd8, 31'd5, 0, 0, 0, 8'd0, 1);   // no quality, kept
    send_entry(1'b0, 16'd7, 31'd8, 31'd7, 0, 0, 1, 8'd20, 0);  // unclosed position
    send_entry(1'b0, 16'd7, 31'd8, 31'h7FFFFFFF, 0, 0, 1, 8'd40, 1); // outside span
    send_entry(1'b0, 16'hFFFF, 31'h7FFFFFFF, 31'd1, 0, 0, 1, 8'd99, 1); // target change
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
    send_entry(1'b0, 16'd0, 31'd0, 31'd0, 0, 0, 1, 8'd1, 1);   // zero-length span
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
    set_config(8'd255, 1'b1, 31'd10, 31'd73, 1'b1, 6'd63);
    send_entry(1'b0, 16'd3, 31'd5, 31'd9, 0, 0, 1, 8'd255, 1);
    send_entry(1'b0, 16'd3, 31'd5, 31'd10, 0, 0, 1, 8'd255, 1);
    send_entry(1'b0, 16'd3, 31'd5, 31'd72, 0, 0, 1, 8'd254, 1);
    send_entry(1'b0, 16'd3, 31'd5, 31'd73, 0, 0, 0, 8'd0, 1);
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
    set_config(8'd0, 1'b1, 31'h7FFFFFFF, 31'd4, 1'b1, 6'd0);  // empty span, zero bins
    send_entry(1'b0, 16'd9, 31'd100, 31'd2, 0, 0, 1, 8'd0, 1);
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
  endtask

  // Random targets, mostly well formed runs of positions with several entries each.
  task automatic test_random(int n_items, logic [5:0] bc, logic hen, logic ren);
    int          sent;
    logic [15:0] tid;
    logic [30:0] tlen;
    logic [30:0] pos;
    int          depth;
    set_config(8'($urandom_range(0, 40)), ren, 31'($urandom_range(0, 20)),
               31'($urandom_range(10, 120)), hen, bc);
    sent = 0;
    while (sent < n_items) begin
      tid = 16'($urandom);
      tlen = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 100));
      pos = 31'($urandom_range(0, 5));
      repeat ($urandom_range(1, 12)) begin
        depth = $urandom_range(1, 4);
        for (int d = 0; d < depth; d++) begin
          if ($urandom_range(0, 29) == 0)
            pos = 31'($urandom);
          random_entry(tid, tlen, pos, (d == depth - 1) || ($urandom_range(0, 19) == 0));
          sent++;
        end
        pos = pos + 31'($urandom_range(1, 4));
      end
      if ($urandom_range(0, 2) == 0) begin
        send_entry(1'b1, 16'($urandom), 31'($urandom), 31'($urandom), 1, 1, 1,
                   8'($urandom), 1);
        sent++;
      end
    end
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    set_config(8'd0, 1'b0, '0, '0, 1'b1, 6'd63);
    allow_idle = 1'b0;
    long_hold = 400;
    for (int t = 0; t < 6; t++)
      for (int p = 0; p < 4; p++)
        send_entry(1'b0, 16'(t), 31'd70, 31'(p * 9), 0, 0, 1, 8'($urandom), 1);
    send_entry(1'b1, '0, '0, '0, 0, 0, 0, '0, 0);
    allow_idle = 1'b1;
  endtask

  initial begin
    m_min_qual = '0; m_region_en = 1'b0; m_region_beg = '0; m_region_end = '0;
    m_hist_en = 1'b0; m_bin_count = BIN_COUNT_RST;
    m_target = '0; m_target_valid = 1'b0; m_span_limit = '0; m_bin_width = '0;
    m_bins_used = '0;
    clear_coverage();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(100, BIN_COUNT_RST, 1'b1, 1'b0);
    test_random(90, 6'd1, 1'b1, 1'b1);
    test_random(80, 6'd63, 1'b0, 1'b0);
    test_random(80, 6'd7, 1'b1, 1'b0);
    drain();
    if (!failed && coverage_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pca_pkg.sv
src/pca_front.sv
src/pca_div.sv
src/pca_back.sv
src/pileup_coverage_accumulator.sv
sim/tb_top.sv
